// File: sv/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types and constants for the setpoint command parser.
// ----------------------------------------------------------------------------
package sspc_pkg;

  localparam int MaxLineDefault        = 255;
  localparam int MaxNumberCharsDefault = 31;
  localparam int FractionDigitsDefault = 3;

  localparam int KeyCount = 7;
  localparam int History  = 9;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [31:0] SatU32 = 32'hFFFF_FFFF;

  // extractor phases
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // value slots
  localparam logic [1:0] SlotSp   = 2'd0;
  localparam logic [1:0] SlotLow  = 2'd1;
  localparam logic [1:0] SlotHigh = 2'd2;
  localparam logic [1:0] SlotHgt  = 2'd3;

  typedef struct packed {
    logic [31:0] setpoint;
    logic [31:0] setpoint_low;
    logic [31:0] setpoint_high;
    logic [31:0] measured_height;
    logic        line_truncated;
  } result_t;

  // a*10+d with saturation at 2^32-1
  function automatic logic [31:0] times_ten_plus(input logic [31:0] a, input logic [3:0] d);
    logic [35:0] v;
    v = {4'd0, a} * 36'd10 + {32'd0, d};
    return (v[35:32] != 4'd0) ? SatU32 : v[31:0];
  endfunction

endpackage

// File: sv/sspc_if.sv
// ----------------------------------------------------------------------------
// sspc_byte_if / sspc_result_if
// Valid/ready channels for received bytes and parsed results.
// ----------------------------------------------------------------------------
interface sspc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sspc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] setpoint;
  logic signed [31:0] setpoint_low;
  logic signed [31:0] setpoint_high;
  logic signed [31:0] measured_height;
  logic        line_truncated;
  modport source (output valid, output setpoint, output setpoint_low,
                  output setpoint_high, output measured_height,
                  output line_truncated, input ready);
  modport sink (input valid, input setpoint, input setpoint_low,
                input setpoint_high, input measured_height,
                input line_truncated, output ready);
endinterface

// File: sv/serial_setpoint_command_parser.sv
// ----------------------------------------------------------------------------
// serial_setpoint_command_parser
// Parses ASCII setpoint command lines into four live values.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one received byte per transfer (rx_byte).
//   out : one transfer per completed line carrying setpoint, setpoint_low,
//         setpoint_high, measured_height and line_truncated.
// CR or LF ends a non-empty line; commas split tokens; a key in a token
// selects which live value takes the token's number. A line longer than
// MAX_LINE ends on the next byte, which is dropped, with line_truncated set.
// A NUL byte ends the line's content.
// Throughput: one byte per cycle, but a line-ending byte can wait (see below).
// Token state sits in registers; the next-value logic is one multiply-by-ten
// step per extractor. A result appears in the output register in the cycle
// after the byte that ends the line is transferred.
// While the output register holds a result the receiver has not taken,
// bytes that do not end a line keep flowing; a byte that would end a line
// waits until the held result is transferred.
// Reset clears token state, line length and all live values to zero.
// ----------------------------------------------------------------------------
module serial_setpoint_command_parser #(
  parameter int MAX_LINE         = sspc_pkg::MaxLineDefault,
  parameter int MAX_NUMBER_CHARS = sspc_pkg::MaxNumberCharsDefault,
  parameter int FRACTION_DIGITS  = sspc_pkg::FractionDigitsDefault
) (
  input logic          clk,
  input logic          rst,
  sspc_byte_if.sink    in_ch,
  sspc_result_if.source out_ch
);
  import sspc_pkg::*;

  localparam int LenW = $clog2(MAX_LINE + 1);

  logic [LenW-1:0] line_len;
  logic            content_ended;
  logic [KeyCount-1:0] keys_seen;
  logic [31:0]     live [4];
  logic            out_valid;
  result_t         out_reg;

  logic acc;

  logic [7:0] c;
  assign c = in_ch.rx_byte;

  // byte classification
  logic is_eol, room, emit, cut, finish, feed, clr;
  always_comb begin
    is_eol = (c == ChCr) || (c == ChLf);
    room   = line_len < LenW'(MAX_LINE);
    emit   = 1'b0;
    cut    = 1'b0;
    finish = 1'b0;
    feed   = 1'b0;
    if (is_eol) begin
      emit   = line_len != '0;
      finish = emit && !content_ended;
    end else if (room) begin
      if (!content_ended) begin
        if (c == ChNul || c == ChComma) finish = 1'b1;
        else                            feed = 1'b1;
      end
    end else begin
      emit   = 1'b1;
      cut    = 1'b1;
      finish = !content_ended;
    end
  end

  // only a line-ending byte needs the output register free
  assign in_ch.ready = !out_valid || out_ch.ready || !emit;
  assign acc = in_ch.valid && in_ch.ready;

  assign clr = rst || (acc && (finish || emit));

  logic [KeyCount-1:0] hits;
  logic [31:0] int_value, dec_value;

  sspc_key_match u_keys (
    .clk(clk), .shift(acc && feed), .clear(clr), .ch(c), .hits(hits)
  );

  sspc_extract #(
    .MAX_NUMBER_CHARS(MAX_NUMBER_CHARS), .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_ext (
    .clk(clk), .shift(acc && feed), .clear(clr), .ch(c),
    .int_value(int_value), .dec_value(dec_value)
  );

  // token end: highest-priority key picks the slot
  logic       store;
  logic [1:0] slot;
  always_comb begin
    store = 1'b1;
    slot  = SlotSp;
    priority if (keys_seen[0]) slot = SlotSp;
    else if (keys_seen[1]) slot = SlotLow;
    else if (keys_seen[2]) slot = SlotHigh;
    else if (keys_seen[3]) slot = SlotSp;
    else if (keys_seen[4]) slot = SlotLow;
    else if (keys_seen[5]) slot = SlotHigh;
    else if (keys_seen[6]) slot = SlotHgt;
    else store = 1'b0;
  end

  logic [31:0] live_next [4];
  always_comb begin
    for (int i = 0; i < 4; i++) live_next[i] = live[i];
    if (finish && store) live_next[slot] = (slot == SlotSp) ? int_value : dec_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len      <= '0;
      content_ended <= 1'b0;
      keys_seen     <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < 4; i++) live[i] <= '0;
    end else begin
      out_valid <= (acc && emit) || (out_valid && !out_ch.ready);
      if (acc) begin
        for (int i = 0; i < 4; i++) live[i] <= live_next[i];
        if (emit) begin
          line_len      <= '0;
          content_ended <= 1'b0;
        end else if (!is_eol) begin
          line_len <= line_len + 1'b1;
          if (!content_ended && c == ChNul) content_ended <= 1'b1;
        end
        if (finish || emit) keys_seen <= '0;
        else if (feed)      keys_seen <= keys_seen | hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      out_reg.setpoint        <= live_next[0];
      out_reg.setpoint_low    <= live_next[1];
      out_reg.setpoint_high   <= live_next[2];
      out_reg.measured_height <= live_next[3];
      out_reg.line_truncated  <= cut;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.setpoint        = out_reg.setpoint;
  assign out_ch.setpoint_low    = out_reg.setpoint_low;
  assign out_ch.setpoint_high   = out_reg.setpoint_high;
  assign out_ch.measured_height = out_reg.measured_height;
  assign out_ch.line_truncated  = out_reg.line_truncated;

endmodule

// File: sv/sspc_key_match.sv
// ----------------------------------------------------------------------------
// sspc_key_match
// Byte history and combinational key hit detection for one byte.
// ----------------------------------------------------------------------------
module sspc_key_match (
  input  logic       clk,
  input  logic       shift,     // byte fed to the token
  input  logic       clear,     // token end
  input  logic [7:0] ch,
  output logic [sspc_pkg::KeyCount-1:0] hits
);
  import sspc_pkg::*;

  logic [7:0] recent [History];

  // recent[0] is the latest byte; key text read backwards
  function automatic logic tail_is(input logic [7:0] c, input logic [7:0] h [History],
                                   input string s);
    logic ok;
    int   n;
    ok = 1'b1;
    n = s.len();
    if (c != s[n-1]) ok = 1'b0;
    for (int i = 0; i < n - 1; i++) begin
      if (h[i] != s[n-2-i]) ok = 1'b0;
    end
    return ok;
  endfunction

  always_comb begin
    hits[0] = tail_is(ch, recent, "Setpoint:");
    hits[1] = tail_is(ch, recent, "Setpointm:");
    hits[2] = tail_is(ch, recent, "SetpointM:");
    hits[3] = tail_is(ch, recent, "SP:");
    hits[4] = tail_is(ch, recent, "Sm:");
    hits[5] = tail_is(ch, recent, "SM:");
    hits[6] = tail_is(ch, recent, "Altura:");
  end

  // history clears with the token; reset reaches it through clear
  always_ff @(posedge clk) begin
    if (clear) begin
      for (int i = 0; i < History; i++) recent[i] <= 8'd0;
    end else if (shift) begin
      recent[0] <= ch;
      for (int i = 1; i < History; i++) recent[i] <= recent[i-1];
    end
  end

endmodule

// File: sv/sspc_extract.sv
// ----------------------------------------------------------------------------
// sspc_extract
// Integer and signed decimal number extractors for the open token.
// ----------------------------------------------------------------------------
module sspc_extract #(
  parameter int MAX_NUMBER_CHARS = sspc_pkg::MaxNumberCharsDefault,
  parameter int FRACTION_DIGITS  = sspc_pkg::FractionDigitsDefault
) (
  input  logic        clk,
  input  logic        shift,
  input  logic        clear,
  input  logic [7:0]  ch,
  output logic [31:0] int_value,
  output logic [31:0] dec_value
);
  import sspc_pkg::*;

  localparam int CntW = $clog2(MAX_NUMBER_CHARS + 1);
  localparam int FdW  = $clog2(FRACTION_DIGITS + 1) + 1;

  phase_t          int_phase, num_phase;
  logic [31:0]     int_acc, num_mag;
  logic [CntW-1:0] int_cnt, num_cnt;
  logic            num_neg;
  logic [1:0]      pt_state;
  logic [FdW-1:0]  frac_cnt;

  logic       digit;
  logic [3:0] dv;
  assign digit = (ch >= ChZero) && (ch <= ChNine);
  assign dv    = 4'(ch - ChZero);

  logic [31:0] int_ten, num_ten;
  assign int_ten = times_ten_plus(int_acc, dv);
  assign num_ten = times_ten_plus(num_mag, dv);

  always_ff @(posedge clk) begin
    if (clear) begin
      int_phase <= PH_SEARCH;
      int_acc   <= '0;
      int_cnt   <= '0;
      num_phase <= PH_SEARCH;
      num_neg   <= 1'b0;
      pt_state  <= 2'd0;
      frac_cnt  <= '0;
      num_mag   <= '0;
      num_cnt   <= '0;
    end else if (shift) begin
      if (int_phase != PH_DONE) begin
        if (digit && int_cnt < CntW'(MAX_NUMBER_CHARS)) begin
          int_acc <= int_ten;
          int_cnt <= int_cnt + 1'b1;
          int_phase <= (int_cnt + 1'b1 >= CntW'(MAX_NUMBER_CHARS)) ? PH_DONE : PH_COLLECT;
        end else if (int_phase == PH_COLLECT) begin
          int_phase <= PH_DONE;
        end
      end
      if (num_phase != PH_DONE) begin
        if ((digit || ch == ChDot || (ch == ChMinus && num_phase == PH_SEARCH))
            && num_cnt < CntW'(MAX_NUMBER_CHARS)) begin
          if (ch == ChMinus) begin
            num_neg <= 1'b1;
          end else if (ch == ChDot) begin
            if (pt_state < 2'd2) pt_state <= pt_state + 2'd1;
          end else if (pt_state == 2'd0) begin
            num_mag <= num_ten;
          end else if (pt_state == 2'd1 && frac_cnt < FdW'(FRACTION_DIGITS)) begin
            num_mag  <= num_ten;
            frac_cnt <= frac_cnt + 1'b1;
          end
          num_cnt <= num_cnt + 1'b1;
          num_phase <= (num_cnt + 1'b1 >= CntW'(MAX_NUMBER_CHARS)) ? PH_DONE : PH_COLLECT;
        end else if (num_phase == PH_COLLECT) begin
          num_phase <= PH_DONE;
        end
      end
    end
  end

  // scale by the missing fraction digits (at most FRACTION_DIGITS small steps)
  logic [31:0] scaled;
  always_comb begin
    scaled = num_mag;
    for (int k = 0; k < FRACTION_DIGITS; k++) begin
      if (FdW'(k) >= frac_cnt) scaled = times_ten_plus(scaled, 4'd0);
    end
    if (num_neg) dec_value = scaled[31] ? 32'h8000_0000 : (32'd0 - scaled);
    else         dec_value = scaled[31] ? 32'h7FFF_FFFF : scaled;
  end

  assign int_value = int_acc;

endmodule

// File: sv/sspc_checker.sv
// ----------------------------------------------------------------------------
// sspc_checker
// Port-level checks on the parser's channels.
// ----------------------------------------------------------------------------
module sspc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_trunc
);
  import sspc_pkg::*;

  // a rising result needs an input transfer in the cycle before
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a transfer");

  // CR/LF ending a line never marks truncation
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_byte == ChCr || in_byte == ChLf) && !(out_valid && !out_ready))
    |=> (!out_valid || !out_trunc || $stable(out_trunc) && !$past(out_ready)) || !$rose(out_valid))
    else $error("truncation flag on CR/LF end");

  // input ready whenever the output register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled needlessly");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_trunc))
    else $error("stalled result changed");

endmodule

bind serial_setpoint_command_parser sspc_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.rx_byte),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_trunc(out_ch.line_truncated)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the setpoint command parser: directed lines covering
// keys, signs, fractions, saturation, NUL and overlong lines, then random
// well-formed command lines mixed with noise, with random gaps and stalls.
// ----------------------------------------------------------------------------
class line_scoreboard;
  sspc_pkg::result_t pending_lines[$];
  int errors;
  int lines_checked;

  function void note_line(sspc_pkg::result_t r);
    pending_lines.push_back(r);
  endfunction

  function void check_line(sspc_pkg::result_t got);
    sspc_pkg::result_t exp;
    if (pending_lines.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp = pending_lines.pop_front();
    lines_checked++;
    if (got.setpoint !== exp.setpoint) begin
      $display("%0t: setpoint exp %0d got %0d", $realtime, exp.setpoint, got.setpoint);
      errors++;
    end
    if (got.setpoint_low !== exp.setpoint_low) begin
      $display("%0t: setpoint_low exp %0d got %0d", $realtime,
               $signed(exp.setpoint_low), $signed(got.setpoint_low));
      errors++;
    end
    if (got.setpoint_high !== exp.setpoint_high) begin
      $display("%0t: setpoint_high exp %0d got %0d", $realtime,
               $signed(exp.setpoint_high), $signed(got.setpoint_high));
      errors++;
    end
    if (got.measured_height !== exp.measured_height) begin
      $display("%0t: measured_height exp %0d got %0d", $realtime,
               $signed(exp.measured_height), $signed(got.measured_height));
      errors++;
    end
    if (got.line_truncated !== exp.line_truncated) begin
      $display("%0t: line_truncated exp %0b got %0b", $realtime,
               exp.line_truncated, got.line_truncated);
      errors++;
    end
  endfunction
endclass

module tb;
  import sspc_pkg::*;

  localparam int LineMax  = MaxLineDefault;
  localparam int NumMax   = MaxNumberCharsDefault;
  localparam int FracMax  = FractionDigitsDefault;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sspc_byte_if   byte_ch ();
  sspc_result_if res_ch ();

  serial_setpoint_command_parser i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (byte_ch.sink),
    .out_ch(res_ch.source)
  );

  always #4 clk = ~clk;

  line_scoreboard sb = new();
  int bytes_sent;

  // ---- predictor state ----
  // Keys in priority order; slot each one writes.
  string      key_str [KeyCount] = '{"Setpoint:", "Setpointm:", "SetpointM:",
                                     "SP:", "Sm:", "SM:", "Altura:"};
  logic [1:0] key_slot[KeyCount] = '{SlotSp, SlotLow, SlotHigh, SlotSp,
                                     SlotLow, SlotHigh, SlotHgt};

  logic [7:0]  hist[History];        // hist[0] is the newest token byte
  logic [6:0]  key_hits;
  int          line_len;
  bit          line_dead;            // content ended by NUL
  phase_t      int_ph;
  logic [31:0] int_acc;
  int          int_cnt;
  phase_t      dec_ph;
  bit          dec_neg;
  int          dec_pts;
  int          dec_frac;
  logic [31:0] dec_mag;
  int          dec_cnt;
  logic [31:0] values[4];

  function automatic logic [31:0] mul10_add(logic [31:0] a, int d);
    logic [35:0] v;
    v = {4'd0, a} * 36'd10 + 36'(d);
    return (v[35:32] != 0) ? SatU32 : v[31:0];
  endfunction

  function automatic void clear_token();
    foreach (hist[i]) hist[i] = '0;
    key_hits = '0;
    int_ph = PH_SEARCH; int_acc = '0; int_cnt = 0;
    dec_ph = PH_SEARCH; dec_neg = 0; dec_pts = 0; dec_frac = 0;
    dec_mag = '0; dec_cnt = 0;
  endfunction

  // Scale the decimal to thousandths, then clamp to the signed range.
  function automatic logic [31:0] scaled_decimal();
    logic [31:0] m;
    m = dec_mag;
    for (int k = dec_frac; k < FracMax; k++) m = mul10_add(m, 0);
    if (dec_neg) return (m >= 32'h8000_0000) ? 32'h8000_0000 : -m;
    return (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
  endfunction

  function automatic void close_token();
    for (int k = 0; k < KeyCount; k++) begin
      if (key_hits[k]) begin
        values[key_slot[k]] = (key_slot[k] == SlotSp) ? int_acc : scaled_decimal();
        break;
      end
    end
    clear_token();
  endfunction

  function automatic void take_token_byte(logic [7:0] c);
    bit dig, hit, grab;
    int n;
    dig = (c >= ChZero && c <= ChNine);
    for (int k = 0; k < KeyCount; k++) begin
      n = key_str[k].len();
      hit = (c == key_str[k][n-1]);
      for (int i = 0; i < n - 1; i++)
        if (hist[i] != key_str[k][n-2-i]) hit = 0;
      if (hit) key_hits[k] = 1'b1;
    end
    for (int i = History - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = c;

    if (int_ph != PH_DONE) begin
      if (dig && int_cnt < NumMax) begin
        int_acc = mul10_add(int_acc, c - ChZero);
        int_cnt++;
        int_ph = (int_cnt >= NumMax) ? PH_DONE : PH_COLLECT;
      end else if (int_ph == PH_COLLECT) int_ph = PH_DONE;
    end

    if (dec_ph != PH_DONE) begin
      grab = dig || c == ChDot || (c == ChMinus && dec_ph == PH_SEARCH);
      if (grab && dec_cnt < NumMax) begin
        if (c == ChMinus) dec_neg = 1;
        else if (c == ChDot) begin
          if (dec_pts < 2) dec_pts++;
        end else if (dec_pts == 0) dec_mag = mul10_add(dec_mag, c - ChZero);
        else if (dec_pts == 1 && dec_frac < FracMax) begin
          dec_mag = mul10_add(dec_mag, c - ChZero);
          dec_frac++;
        end
        dec_cnt++;
        dec_ph = (dec_cnt >= NumMax) ? PH_DONE : PH_COLLECT;
      end else if (dec_ph == PH_COLLECT) dec_ph = PH_DONE;
    end
  endfunction

  // Advance the predictor by one accepted byte; queue a line result if due.
  function automatic void predict_byte(logic [7:0] c);
    bit done, cut;
    result_t r;
    done = 0; cut = 0;
    if (c == ChCr || c == ChLf) begin
      if (line_len > 0) begin
        if (!line_dead) close_token();
        done = 1;
      end
    end else if (line_len < LineMax) begin
      line_len++;
      if (!line_dead) begin
        if (c == ChNul) begin
          close_token();
          line_dead = 1;
        end else if (c == ChComma) close_token();
        else take_token_byte(c);
      end
    end else begin
      if (!line_dead) close_token();
      done = 1; cut = 1;
    end
    if (done) begin
      r.setpoint = values[SlotSp];
      r.setpoint_low = values[SlotLow];
      r.setpoint_high = values[SlotHigh];
      r.measured_height = values[SlotHgt];
      r.line_truncated = cut;
      sb.note_line(r);
      line_len = 0;
      line_dead = 0;
      clear_token();
    end
  endfunction

  // ---- sender ----
  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so the next call or the caller drops it.
  task automatic send_byte(logic [7:0] c);
    int gap;
    gap = (bytes_sent % 200 < 40) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= c;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predict_byte(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(ChZero + $urandom_range(0, 9)))};
    return s;
  endfunction

  // Random number text: sign, integer digits, point, fraction, sometimes junk.
  function automatic string rand_number();
    string s;
    s = ($urandom_range(0, 2) == 0) ? "-" : "";
    s = {s, rand_digits($urandom_range(0, ($urandom_range(0, 9) == 0) ? 14 : 5))};
    if ($urandom_range(0, 1)) s = {s, ".", rand_digits($urandom_range(0, 6))};
    if ($urandom_range(0, 9) == 0) s = {s, ".", rand_digits(2)};
    if ($urandom_range(0, 9) == 0) s = {s, "-", rand_digits(2)};
    return s;
  endfunction

  function automatic string rand_line();
    string s, keys[8];
    int nt;
    keys = '{"Setpoint:", "Setpointm:", "SetpointM:", "SP:", "Sm:", "SM:",
             "Altura:", "Xy:"};
    s = "";
    nt = $urandom_range(1, 3);
    for (int t = 0; t < nt; t++) begin
      if (t > 0) s = {s, ","};
      if ($urandom_range(0, 3) == 0) s = {s, " "};
      s = {s, keys[$urandom_range(0, 7)], rand_number()};
      // occasional second key in the same token exercises priority
      if ($urandom_range(0, 7) == 0) s = {s, keys[$urandom_range(0, 6)], rand_number()};
    end
    return s;
  endfunction

  // ---- receiver: random stalls, checks on each transfer ----
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= (bytes_sent % 300 < 60) ? 1'b1 : ($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.setpoint = res_ch.setpoint;
      got.setpoint_low = res_ch.setpoint_low;
      got.setpoint_high = res_ch.setpoint_high;
      got.measured_height = res_ch.measured_height;
      got.line_truncated = res_ch.line_truncated;
      sb.check_line(got);
    end
  end

  // ---- stimulus ----
  initial begin
    int guard;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    line_len = 0; line_dead = 0;
    foreach (values[i]) values[i] = '0;
    clear_token();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: each key, signs, truncated fraction, saturation, double point
    send_text("\n");                                  // empty line: no result
    send_text("Setpoint:42,Setpointm:-1.2345\r");
    send_text("SetpointM:99999999999,SP:7,Sm:.5\n");
    send_text("SM:-99999999999.9,Altura:3.1.4\n");
    send_text("Altura:12-3, junk 55,Xy:9\n");
    send_text("SP:99999999999999999999\n");           // integer saturation
    send_text({"Sm:", rand_digits(40), "\n"});        // character count limit
    send_text("Setpoint:1SP:2\n");                    // priority within a token
    send_byte(8'hFF); send_byte(8'h80); send_text("SP:5"); send_byte(ChNul);
    send_text("SP:6\r");                              // NUL ends content
    send_byte(ChNul); send_text("\n");                // empty content line
    for (int i = 0; i < LineMax; i++) send_byte(i % 2 ? "9" : "S");
    send_text("Z");                                   // overlong, byte dropped
    send_text("\n");                                  // now empty
    byte_ch.valid <= 1'b0;

    // pause until every expected line has been checked
    while (sb.pending_lines.size() != 0) @(negedge clk);

    while (bytes_sent < 880) begin
      case ($urandom_range(0, 19))
        0: send_byte($urandom_range(0, 255));          // noise byte
        1: send_byte(ChNul);
        default: begin
          send_text(rand_line());
          send_byte($urandom_range(0, 1) ? ChCr : ChLf);
        end
      endcase
    end
    // one more overlong line, bit-rich bytes
    for (int i = 0; i <= LineMax; i++) send_byte($urandom_range(14, 255));
    send_byte(ChLf);
    byte_ch.valid <= 1'b0;

    guard = 0;
    while (sb.pending_lines.size() != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    $display("tb: %0d bytes sent, %0d lines checked; keys, signs, fractions,",
             bytes_sent, sb.lines_checked);
    $display("tb: saturation, NUL and overlong lines exercised");
    if (sb.errors == 0 && sb.pending_lines.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule

// File: sim.f
sv/sspc_pkg.sv
sv/sspc_if.sv
sv/sspc_key_match.sv
sv/sspc_extract.sv
sv/serial_setpoint_command_parser.sv
sv/sspc_checker.sv
dv/tb.sv
